[design/btr_pkg.sv]
// Shared types and constants of the broadcast transport reassembler.
// Used by btr_front, btr_back and bam_transport_reassembler; depends on nothing.
package btr_pkg;

   localparam int unsigned MAX_MESSAGE_BYTES = 512;
   localparam int unsigned SOURCE_COUNT      = 256;
   localparam int unsigned WORDS_PER_SESSION = (MAX_MESSAGE_BYTES + 7) / 8;
   localparam int unsigned WIDX_W            = $clog2(WORDS_PER_SESSION);
   localparam int unsigned QUEUE_DEPTH       = 2;

   localparam logic [17:0] GRP_ANNOUNCE     = 18'h0EC00;
   localparam logic [17:0] GRP_DATA         = 18'h0EB00;
   localparam logic [7:0]  CTRL_BAM         = 8'h20;
   localparam logic [3:0]  MIN_FRAME_LENGTH = 4'd8;

   // Work kinds passed from the front end to the back end.
   localparam logic [1:0] KIND_ANNOUNCE = 2'd0;
   localparam logic [1:0] KIND_DATA     = 2'd1;
   localparam logic [1:0] KIND_KILL     = 2'd2;
   localparam logic [1:0] KIND_EXPIRE   = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  sa;
      logic [7:0]  da;
      logic [63:0] payload;
      logic [63:0] time_us;
   } cmd_type;

   typedef struct packed {
      logic        valid;
      cmd_type     head;
   } queue_out_type;

   typedef struct packed {
      logic [9:0]  total;
      logic [7:0]  packets;
      logic [23:0] grp;
      logic [7:0]  dest;
      logic [7:0]  received;
   } meta_type;

endpackage

[design/bam_transport_reassembler.sv]
// Top level of the broadcast transport reassembler: register, front end, back end.
// Depends on btr_pkg, btr_front and btr_back.
//
// Usage. A word is accepted on the req_ ports at a rising edge where start is
// high and busy is low. Short frames and frames of other groups are taken and
// dropped at once; useful words go into a two-entry queue, so busy is high only
// while that queue is full.
// The back end takes one queued word at a time. An announcement clears the
// 64-word buffer of its source, one word per cycle. A data frame without a
// session is only popped; otherwise the sequencer checks its sequence number
// against the session metadata and, when it has bytes to store, reads and
// merges one or two buffer words. When it completes a message the words
// follow on rsp_ one per cycle, up to 64 of them, with rsp_last_word on the
// final one. rsp_strobe marks each word for one cycle and the receiver cannot
// hold them off. The expire command walks all 256 sessions, one per cycle.
// The user must write the idle timeout through csr_wr_en and csr_wr_data only
// while idle; the block itself does not enforce this.
// Reset clears the queue, all session flags and the back-end sequencer, and
// sets the timeout to 750000 microseconds; the buffers are not cleared.
module bam_transport_reassembler
   import btr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [17:0] req_group_number,
   input  logic [7:0]  req_source_addr,
   input  logic [7:0]  req_dest_addr,
   input  logic [63:0] req_payload,
   input  logic [3:0]  req_frame_length,
   input  logic [63:0] req_time_us,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output logic        rsp_strobe,
   output logic [23:0] rsp_msg_group_number,
   output logic [7:0]  rsp_msg_source,
   output logic [7:0]  rsp_msg_dest,
   output logic [9:0]  rsp_msg_total_bytes,
   output logic [5:0]  rsp_word_index,
   output logic [63:0] rsp_data_word,
   output logic        rsp_last_word
);

   // Idle timeout register.
   logic [31:0]   timeout_ff, timeout_in;
   queue_out_type q_out;
   logic          q_pop;

   assign timeout_in = csr_wr_en ? csr_wr_data : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= 32'd750000;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   // The front end classifies and queues words.
   btr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_group_number (req_group_number),
      .req_source_addr  (req_source_addr),
      .req_dest_addr    (req_dest_addr),
      .req_payload      (req_payload),
      .req_frame_length (req_frame_length),
      .req_time_us      (req_time_us),
      .q_out            (q_out),
      .q_pop            (q_pop)
   );

   // The back end keeps the sessions and emits finished messages.
   btr_back u_back (
      .clock                (clock),
      .reset                (reset),
      .idle_limit_us        (timeout_ff),
      .q_out                (q_out),
      .q_pop                (q_pop),
      .rsp_strobe           (rsp_strobe),
      .rsp_msg_group_number (rsp_msg_group_number),
      .rsp_msg_source       (rsp_msg_source),
      .rsp_msg_dest         (rsp_msg_dest),
      .rsp_msg_total_bytes  (rsp_msg_total_bytes),
      .rsp_word_index       (rsp_word_index),
      .rsp_data_word        (rsp_data_word),
      .rsp_last_word        (rsp_last_word)
   );

`ifndef SYNTHESIS
   // After reset the queue is empty, so the block is ready.
   assert property (@(posedge clock) reset |=> !busy)
      else $error("busy after reset");

   // Words of one message come in consecutive cycles with rising index.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_word |=>
         rsp_strobe && rsp_word_index == $past(rsp_word_index) + 6'd1)
      else $error("message words not contiguous");

   // A new message cannot start right after a final word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_word |=> !rsp_strobe)
      else $error("word after final word");
`endif

endmodule

[design/btr_front.sv]
// Front end: accepts words, classifies them and queues the useful ones.
// Depends on btr_pkg.
module btr_front
   import btr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic          req_command,
   input  logic [17:0]   req_group_number,
   input  logic [7:0]    req_source_addr,
   input  logic [7:0]    req_dest_addr,
   input  logic [63:0]   req_payload,
   input  logic [3:0]    req_frame_length,
   input  logic [63:0]   req_time_us,
   output queue_out_type q_out,
   input  logic          q_pop
);

   cmd_type     fifo_ff [QUEUE_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   cmd_type     item;
   logic        keep;
   logic        push;

   always_comb begin
      item.kind    = KIND_DATA;
      item.sa      = req_source_addr;
      item.da      = req_dest_addr;
      item.payload = req_payload;
      item.time_us = req_time_us;
      keep         = 1'b0;
      if (req_command) begin
         item.kind = KIND_EXPIRE;
         keep      = 1'b1;
      end else if (req_frame_length >= MIN_FRAME_LENGTH &&
                   {1'b0, req_source_addr} < 9'(SOURCE_COUNT)) begin
         if (req_group_number == GRP_ANNOUNCE && req_payload[7:0] == CTRL_BAM) begin
            keep      = 1'b1;
            item.kind = (req_payload[23:8] > 16'(MAX_MESSAGE_BYTES)) ? KIND_KILL
                                                                     : KIND_ANNOUNCE;
         end else if (req_group_number == GRP_DATA) begin
            keep = 1'b1;
         end
      end
   end

   assign busy        = (count_ff == 2'(QUEUE_DEPTH));
   assign push        = start && !busy && keep;
   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.head  = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

[design/btr_back.sv]
// Back end: session table, message buffer and the sequencer that works on them.
// Depends on btr_pkg.
module btr_back
   import btr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [31:0]   idle_limit_us,
   input  queue_out_type q_out,
   output logic          q_pop,
   output logic          rsp_strobe,
   output logic [23:0]   rsp_msg_group_number,
   output logic [7:0]    rsp_msg_source,
   output logic [7:0]    rsp_msg_dest,
   output logic [9:0]    rsp_msg_total_bytes,
   output logic [5:0]    rsp_word_index,
   output logic [63:0]   rsp_data_word,
   output logic          rsp_last_word
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_ZERO    = 4'd1;
   localparam logic [3:0] S_DMETA   = 4'd2;
   localparam logic [3:0] S_RD0     = 4'd3;
   localparam logic [3:0] S_MG0     = 4'd4;
   localparam logic [3:0] S_RD1     = 4'd5;
   localparam logic [3:0] S_MG1     = 4'd6;
   localparam logic [3:0] S_EMIT    = 4'd7;
   localparam logic [3:0] S_EXP     = 4'd8;
   localparam logic [3:0] S_EXP_END = 4'd9;

   localparam int unsigned BUF_DEPTH = SOURCE_COUNT * WORDS_PER_SESSION;
   localparam int unsigned BUF_AW    = 8 + WIDX_W;

   meta_type    meta_mem [SOURCE_COUNT];
   logic [63:0] time_mem [SOURCE_COUNT];
   logic [63:0] buf_mem  [BUF_DEPTH];

   logic [3:0]              state_ff, state_in;
   cmd_type                 cur_ff, cur_in;
   logic [SOURCE_COUNT-1:0] active_ff, active_in;
   logic [7:0]              cnt_ff, cnt_in;
   meta_type                meta_ff, meta_in;
   logic [10:0]             offset_ff, offset_in;
   logic [2:0]              nbytes_ff, nbytes_in;
   logic                    complete_ff, complete_in;
   logic                    pend_ff, pend_in;
   logic [WIDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic                    pend_last_ff, pend_last_in;
   logic                    exp_pend_ff, exp_pend_in;
   logic [7:0]              exp_idx_ff, exp_idx_in;

   meta_type    meta_rd_ff;
   logic [63:0] time_rd_ff;
   logic [63:0] buf_rd_ff;

   logic              meta_we;
   logic [7:0]        meta_wa, meta_ra;
   meta_type          meta_wd;
   logic              time_we;
   logic [7:0]        time_wa, time_ra;
   logic [63:0]       time_wd;
   logic              buf_we;
   logic [BUF_AW-1:0] buf_wa, buf_ra;
   logic [63:0]       buf_wd;

   logic [7:0]        seq;
   logic [10:0]       seq_m1;
   logic [10:0]       off;
   logic [10:0]       diff;
   logic [7:0]        recv_next;
   logic [WIDX_W-1:0] w0, w1;
   logic [10:0]       last_byte;
   logic [10:0]       word_count;
   logic [WIDX_W-1:0] last_widx;
   logic [63:0]       idle_time;

   // Places the frame bytes that fall into one buffer word over the old contents.
   function automatic logic [63:0] merge_word(input logic [63:0]       old,
                                              input logic [WIDX_W-1:0] widx,
                                              input logic [10:0]       offset,
                                              input logic [2:0]        n,
                                              input logic [63:0]       pl);
      logic [63:0] res;
      logic [10:0] abs_idx;
      logic [10:0] rel;
      logic [2:0]  sel;
      res = old;
      for (int b = 0; b < 8; b++) begin
         abs_idx = 11'({widx, 3'(b)});
         rel     = abs_idx - offset;
         sel     = rel[2:0] + 3'd1;
         if (abs_idx >= offset && abs_idx < offset + 11'(n)) begin
            res[8*b +: 8] = pl[{sel, 3'b000} +: 8];
         end
      end
      return res;
   endfunction

   assign seq        = cur_ff.payload[7:0];
   assign seq_m1     = 11'(seq) - 11'd1;
   assign off        = (seq_m1 << 3) - seq_m1;
   assign diff       = 11'(meta_rd_ff.total) - off;
   assign recv_next  = meta_rd_ff.received + 8'd1;
   assign w0         = offset_ff[WIDX_W+2:3];
   assign last_byte  = offset_ff + 11'(nbytes_ff) - 11'd1;
   assign w1         = last_byte[WIDX_W+2:3];
   assign word_count = (11'(meta_ff.total) + 11'd7) >> 3;
   assign last_widx  = (meta_ff.total == 10'd0) ? '0 : WIDX_W'(word_count - 11'd1);
   assign idle_time  = cur_ff.time_us - time_rd_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      active_in    = active_ff;
      cnt_in       = cnt_ff;
      meta_in      = meta_ff;
      offset_in    = offset_ff;
      nbytes_in    = nbytes_ff;
      complete_in  = complete_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      pend_last_in = pend_last_ff;
      exp_pend_in  = 1'b0;
      exp_idx_in   = exp_idx_ff;
      q_pop        = 1'b0;
      meta_we      = 1'b0;
      meta_wa      = cur_ff.sa;
      meta_wd      = meta_ff;
      meta_ra      = q_out.head.sa;
      time_we      = 1'b0;
      time_wa      = q_out.head.sa;
      time_wd      = q_out.head.time_us;
      time_ra      = cnt_ff;
      buf_we       = 1'b0;
      buf_wa       = {cur_ff.sa, w0};
      buf_wd       = '0;
      buf_ra       = {cur_ff.sa, w0};

      if (exp_pend_ff && idle_time > {32'd0, idle_limit_us}) begin
         active_in[exp_idx_ff] = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (q_out.valid) begin
               q_pop  = 1'b1;
               cur_in = q_out.head;
               unique case (q_out.head.kind)
                  KIND_ANNOUNCE: begin
                     active_in[q_out.head.sa] = 1'b1;
                     meta_we          = 1'b1;
                     meta_wa          = q_out.head.sa;
                     meta_wd.total    = q_out.head.payload[17:8];
                     meta_wd.packets  = q_out.head.payload[31:24];
                     meta_wd.grp      = q_out.head.payload[63:40];
                     meta_wd.dest     = q_out.head.da;
                     meta_wd.received = 8'd0;
                     time_we          = 1'b1;
                     cnt_in           = 8'd0;
                     state_in         = S_ZERO;
                  end
                  KIND_KILL: begin
                     active_in[q_out.head.sa] = 1'b0;
                  end
                  KIND_DATA: begin
                     if (active_ff[q_out.head.sa]) begin
                        time_we  = 1'b1;
                        state_in = S_DMETA;
                     end
                  end
                  KIND_EXPIRE: begin
                     cnt_in   = 8'd0;
                     state_in = S_EXP;
                  end
                  default: ;
               endcase
            end
         end
         S_ZERO: begin
            buf_we = 1'b1;
            buf_wa = {cur_ff.sa, cnt_ff[WIDX_W-1:0]};
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff[WIDX_W-1:0] == WIDX_W'(WORDS_PER_SESSION - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_DMETA: begin
            meta_in = meta_rd_ff;
            if (seq == 8'd0 || seq > meta_rd_ff.packets) begin
               state_in = S_IDLE;
            end else begin
               meta_we          = 1'b1;
               meta_wd          = meta_rd_ff;
               meta_wd.received = recv_next;
               meta_in.received = recv_next;
               complete_in      = (recv_next >= meta_rd_ff.packets);
               offset_in        = off;
               cnt_in           = 8'd0;
               if (off < 11'(meta_rd_ff.total)) begin
                  nbytes_in = (diff > 11'd7) ? 3'd7 : diff[2:0];
                  state_in  = S_RD0;
               end else begin
                  nbytes_in = 3'd0;
                  state_in  = (recv_next >= meta_rd_ff.packets) ? S_EMIT : S_IDLE;
               end
            end
         end
         S_RD0: begin
            buf_ra   = {cur_ff.sa, w0};
            state_in = S_MG0;
         end
         S_MG0: begin
            buf_we = 1'b1;
            buf_wa = {cur_ff.sa, w0};
            buf_wd = merge_word(buf_rd_ff, w0, offset_ff, nbytes_ff, cur_ff.payload);
            if (w1 != w0) begin
               state_in = S_RD1;
            end else begin
               state_in = complete_ff ? S_EMIT : S_IDLE;
            end
         end
         S_RD1: begin
            buf_ra   = {cur_ff.sa, w1};
            state_in = S_MG1;
         end
         S_MG1: begin
            buf_we   = 1'b1;
            buf_wa   = {cur_ff.sa, w1};
            buf_wd   = merge_word(buf_rd_ff, w1, offset_ff, nbytes_ff, cur_ff.payload);
            state_in = complete_ff ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            buf_ra       = {cur_ff.sa, cnt_ff[WIDX_W-1:0]};
            pend_in      = 1'b1;
            pend_idx_in  = cnt_ff[WIDX_W-1:0];
            pend_last_in = (cnt_ff[WIDX_W-1:0] == last_widx);
            cnt_in       = cnt_ff + 8'd1;
            if (cnt_ff[WIDX_W-1:0] == last_widx) begin
               active_in[cur_ff.sa] = 1'b0;
               state_in             = S_IDLE;
            end
         end
         S_EXP: begin
            time_ra     = cnt_ff;
            exp_pend_in = 1'b1;
            exp_idx_in  = cnt_ff;
            cnt_in      = cnt_ff + 8'd1;
            if (cnt_ff == 8'(SOURCE_COUNT - 1)) begin
               state_in = S_EXP_END;
            end
         end
         S_EXP_END: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         active_ff   <= '0;
         pend_ff     <= 1'b0;
         exp_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         active_ff   <= active_in;
         pend_ff     <= pend_in;
         exp_pend_ff <= exp_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      cnt_ff       <= cnt_in;
      meta_ff      <= meta_in;
      offset_ff    <= offset_in;
      nbytes_ff    <= nbytes_in;
      complete_ff  <= complete_in;
      pend_idx_ff  <= pend_idx_in;
      pend_last_ff <= pend_last_in;
      exp_idx_ff   <= exp_idx_in;
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_wa] <= meta_wd;
      end
      meta_rd_ff <= meta_mem[meta_ra];
   end

   always_ff @(posedge clock) begin
      if (time_we) begin
         time_mem[time_wa] <= time_wd;
      end
      time_rd_ff <= time_mem[time_ra];
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_wa] <= buf_wd;
      end
      buf_rd_ff <= buf_mem[buf_ra];
   end

   assign rsp_strobe           = pend_ff;
   assign rsp_msg_group_number = meta_ff.grp;
   assign rsp_msg_source       = cur_ff.sa;
   assign rsp_msg_dest         = meta_ff.dest;
   assign rsp_msg_total_bytes  = meta_ff.total;
   assign rsp_word_index       = 6'(pend_idx_ff);
   assign rsp_data_word        = buf_rd_ff;
   assign rsp_last_word        = pend_last_ff;

endmodule
